// File: hdl/writeback_block_cache_tags_core_macros.svh
// Assertion macros for the block cache tag core.
// Used by the top level; the including module provides i_clk and i_rst_n.
`ifndef WRITEBACK_BLOCK_CACHE_TAGS_CORE_MACROS_SVH
`define WRITEBACK_BLOCK_CACHE_TAGS_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define WBCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define WBCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/wbct_pkg.sv
// Shared types, constants and helpers of the block cache tag core.
// No dependencies; used by the engine and the top level.
`timescale 1ns / 1ps

package wbct_pkg;

    localparam int SLOTS   = 64;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int TAG_W   = 32;
    localparam int KEY_W   = 8 + TAG_W;
    localparam int MAX_OUT = 64;
    localparam int NOUT_W  = $clog2(MAX_OUT + 1);
    localparam int CNT_W   = $clog2(SLOTS + 1);

    // Operation codes of an input item.
    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_SYNC  = 3'd2;
    localparam logic [2:0] OP_INV   = 3'd3;
    localparam logic [2:0] OP_FAIL  = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_DONE  = 2'd0;
    localparam logic [1:0] KIND_WB    = 2'd1;
    localparam logic [1:0] KIND_FILL  = 2'd2;
    localparam logic [1:0] KIND_ALLOC = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  disk;
        logic [31:0] block_number;
        logic        all_disks;
        logic [5:0]  failed_slot;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  slot;
        logic [7:0]  target_disk;
        logic [34:0] sector_address;
        logic        hit;
        logic [6:0]  count;
        logic        last;
    } t_result;

    // Builds one result item; the sector is the block tag times eight.
    function automatic t_result mk_result(logic [1:0] kind, logic [5:0] slot,
                                          logic [7:0] dsk, logic [TAG_W-1:0] tag,
                                          logic hit, logic [6:0] cnt, logic last);
        t_result r;
        r.kind           = kind;
        r.slot           = slot;
        r.target_disk    = dsk;
        r.sector_address = 35'({tag, 3'b000});
        r.hit            = hit;
        r.count          = cnt;
        r.last           = last;
        return r;
    endfunction

    // Saturates a slot count to the seven-bit result field.
    function automatic logic [6:0] sat_count(logic [CNT_W-1:0] c);
        logic [6:0] r;
        r = (32'(c) > 32'd127) ? 7'd127 : 7'(c);
        return r;
    endfunction

endpackage

// File: hdl/writeback_block_cache_tags_core.sv
// Top level of the write-back block cache tag core: stream ports and output register.
// Depends on wbct_pkg, wbct_engine and the assertion macro header.
//
//  channel    | direction | payload
//  s_axis     | in        | tuser: op, all_disks; tdata: disk, block_number, failed_slot
//  m_axis     | out       | tuser: kind, hit; tdata: slot, target_disk, sector_address,
//             |           |   count; tlast: last
//
// Tags sit in one RAM with a registered read; each slot visit has two steps (read,
// evaluate), and a scan visits all 64 slots.
// Read/write: slots are visited up to the hit; a miss scans all slots, then reads the victim and fills it.
// Sync/invalidate: a scan of all slots, then the final result; fill-failed: answered from idle.
// Reset clears valid, dirty and the victim pointer at once; no clearing pass.
// A stalled output register holds the sequencer in any state that must push an item until the item is taken.
`timescale 1ns / 1ps
`include "writeback_block_cache_tags_core_macros.svh"

module writeback_block_cache_tags_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // disk[7:0], block_number[39:8], failed_slot[45:40]
    input  logic [3:0]  i_s_axis_tuser,  // op[2:0], all_disks[3]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,  // slot[5:0], target_disk[13:6],
                                         // sector_address[48:14], count[55:49]
    output logic [2:0]  o_m_axis_tuser,  // kind[1:0], hit[2]
    output logic        o_m_axis_tlast
);

    wbct_pkg::t_req    req;
    wbct_pkg::t_result eng_res;
    wbct_pkg::t_result r_out;
    logic              r_ovalid;
    logic              can_emit;
    logic              eng_push;

    // Unpack the input item.
    always_comb begin
        req.op           = i_s_axis_tuser[2:0];
        req.all_disks    = i_s_axis_tuser[3];
        req.disk         = i_s_axis_tdata[7:0];
        req.block_number = i_s_axis_tdata[39:8];
        req.failed_slot  = i_s_axis_tdata[45:40];
    end

    assign can_emit = !r_ovalid || i_m_axis_tready;

    wbct_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_req       (req),
        .i_can_emit  (can_emit),
        .o_push      (eng_push),
        .o_res       (eng_res)
    );

    // Output register: loads a new item whenever the old one is gone or taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (can_emit) begin
            r_ovalid <= eng_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_emit && eng_push) begin
            r_out <= eng_res;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_out.count, r_out.sector_address, r_out.target_disk, r_out.slot};
    assign o_m_axis_tuser  = {r_out.hit, r_out.kind};
    assign o_m_axis_tlast  = r_out.last;

    `WBCT_ASSERT_NOW(a_push_has_room, eng_push, can_emit, "result pushed into a full output register")
    `WBCT_ASSERT_NEXT(a_nonlast_keeps_busy, eng_push && !eng_res.last, !o_s_axis_tready, "input taken before the final result")
    `WBCT_ASSERT_NOW(a_done_is_last, o_m_axis_tvalid && (o_m_axis_tuser[1:0] == wbct_pkg::KIND_DONE), o_m_axis_tlast, "result without command not marked last")

endmodule

// File: hdl/wbct_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module wbct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/wbct_engine.sv
// Lookup, replacement and sync/invalidate sequencer of the tag core.
// Depends on wbct_pkg and wbct_ram (tag store of disk and block tags).
`timescale 1ns / 1ps

module wbct_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  wbct_pkg::t_req    i_req,
    input  logic              i_can_emit,
    output logic              o_push,
    output wbct_pkg::t_result o_res
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_EV   = 7'b0000100,
        S_VRD  = 7'b0001000,
        S_VEV  = 7'b0010000,
        S_FILL = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    localparam logic [wbct_pkg::IDX_W-1:0] LAST_IDX =
        wbct_pkg::IDX_W'(wbct_pkg::SLOTS - 1);

    t_state                          r_state, n_state;
    wbct_pkg::t_req                  r_req, n_req;
    logic [wbct_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic [wbct_pkg::IDX_W-1:0]      r_vp, n_vp;
    logic [wbct_pkg::SLOTS-1:0]      r_valid, n_valid;
    logic [wbct_pkg::SLOTS-1:0]      r_dirty, n_dirty;
    logic [wbct_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [wbct_pkg::NOUT_W-1:0]     r_nout, n_nout;
    logic                            r_pend_v, n_pend_v;
    wbct_pkg::t_result               r_pend, n_pend;

    logic                            mem_we;
    logic [wbct_pkg::KEY_W-1:0]      mem_rdata;
    logic [7:0]                      rd_disk;
    logic [wbct_pkg::TAG_W-1:0]      rd_tag;
    logic [wbct_pkg::TAG_W-1:0]      req_tag;
    logic                            is_lookup;
    logic                            match;
    logic                            sel;
    logic                            take_wb;

    // Tag store: disk tag above block tag, addressed by the current slot.
    wbct_ram #(
        .WIDTH (wbct_pkg::KEY_W),
        .DEPTH (wbct_pkg::SLOTS)
    ) u_tags (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_idx),
        .i_wdata ({r_req.disk, req_tag}),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    assign rd_disk   = mem_rdata[wbct_pkg::KEY_W-1:wbct_pkg::TAG_W];
    assign rd_tag    = mem_rdata[wbct_pkg::TAG_W-1:0];
    assign req_tag   = wbct_pkg::TAG_W'(r_req.block_number);
    assign is_lookup = (r_req.op == wbct_pkg::OP_READ) || (r_req.op == wbct_pkg::OP_WRITE);
    assign match     = r_valid[r_idx] && (rd_disk == r_req.disk) && (rd_tag == req_tag);

    // Slot selection of a sync or invalidate scan.
    always_comb begin
        if (r_req.op == wbct_pkg::OP_SYNC) begin
            sel = r_valid[r_idx] && r_dirty[r_idx] &&
                  (r_req.all_disks || (rd_disk == r_req.disk));
        end else begin
            sel = r_valid[r_idx] && (rd_disk == r_req.disk);
        end
    end
    assign take_wb = sel && r_dirty[r_idx] && (32'(r_nout) < wbct_pkg::MAX_OUT);

    assign o_req_ready = (r_state == S_IDLE) && i_can_emit;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_idx    = r_idx;
        n_vp     = r_vp;
        n_valid  = r_valid;
        n_dirty  = r_dirty;
        n_cnt    = r_cnt;
        n_nout   = r_nout;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        mem_we   = 1'b0;
        o_push   = 1'b0;
        o_res    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid && o_req_ready) begin
                    n_req    = i_req;
                    n_idx    = '0;
                    n_cnt    = '0;
                    n_nout   = '0;
                    n_pend_v = 1'b0;
                    case (i_req.op) inside
                        wbct_pkg::OP_READ, wbct_pkg::OP_WRITE,
                        wbct_pkg::OP_SYNC, wbct_pkg::OP_INV: begin
                            n_state = S_RD;
                        end
                        wbct_pkg::OP_FAIL: begin
                            if (32'(i_req.failed_slot) < wbct_pkg::SLOTS) begin
                                n_valid[wbct_pkg::IDX_W'(i_req.failed_slot)] = 1'b0;
                                n_dirty[wbct_pkg::IDX_W'(i_req.failed_slot)] = 1'b0;
                            end
                            o_push = 1'b1;
                            o_res  = wbct_pkg::mk_result(wbct_pkg::KIND_DONE,
                                i_req.failed_slot, 8'd0, '0, 1'b0, 7'd0, 1'b1);
                        end
                        default: begin
                            o_push = 1'b1;
                            o_res  = wbct_pkg::mk_result(wbct_pkg::KIND_DONE,
                                6'd0, 8'd0, '0, 1'b0, 7'd0, 1'b1);
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                if (is_lookup) begin
                    if (match) begin
                        if (i_can_emit) begin
                            o_push = 1'b1;
                            o_res  = wbct_pkg::mk_result(wbct_pkg::KIND_DONE, 6'(r_idx),
                                r_req.disk, req_tag, 1'b1, 7'd0, 1'b1);
                            if (r_req.op == wbct_pkg::OP_WRITE) begin
                                n_dirty[r_idx] = 1'b1;
                            end
                            n_state = S_IDLE;
                        end
                    end else if (r_idx == LAST_IDX) begin
                        // Miss: the victim is the round-robin slot.
                        n_idx   = r_vp;
                        n_vp    = (r_vp == LAST_IDX) ? '0 : r_vp + 1'b1;
                        n_state = S_VRD;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end else if (!(take_wb && r_pend_v && !i_can_emit)) begin
                    // A new writeback releases the held one as a non-final item.
                    if (take_wb) begin
                        if (r_pend_v) begin
                            o_push = 1'b1;
                            o_res  = r_pend;
                        end
                        n_pend_v = 1'b1;
                        n_pend   = wbct_pkg::mk_result(wbct_pkg::KIND_WB, 6'(r_idx),
                            rd_disk, rd_tag, 1'b0, 7'd0, 1'b0);
                        n_nout   = r_nout + 1'b1;
                        n_dirty[r_idx] = 1'b0;
                    end
                    if (sel && (take_wb || !r_dirty[r_idx])) begin
                        if (r_req.op == wbct_pkg::OP_INV) begin
                            n_valid[r_idx] = 1'b0;
                        end
                        n_cnt = r_cnt + 1'b1;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_VRD: begin
                n_state = S_VEV;
            end
            S_VEV: begin
                if (r_valid[r_idx] && r_dirty[r_idx]) begin
                    if (i_can_emit) begin
                        o_push  = 1'b1;
                        o_res   = wbct_pkg::mk_result(wbct_pkg::KIND_WB, 6'(r_idx),
                            rd_disk, rd_tag, 1'b0, 7'd0, 1'b0);
                        n_state = S_FILL;
                    end
                end else begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (i_can_emit) begin
                    mem_we         = 1'b1;
                    n_valid[r_idx] = 1'b1;
                    n_dirty[r_idx] = (r_req.op == wbct_pkg::OP_WRITE);
                    o_push         = 1'b1;
                    o_res          = wbct_pkg::mk_result(
                        (r_req.op == wbct_pkg::OP_READ) ? wbct_pkg::KIND_FILL
                                                        : wbct_pkg::KIND_ALLOC,
                        6'(r_idx), r_req.disk, req_tag, 1'b0, 7'd0, 1'b1);
                    n_state        = S_IDLE;
                end
            end
            S_FIN: begin
                if (i_can_emit) begin
                    o_push = 1'b1;
                    if (r_pend_v) begin
                        o_res       = r_pend;
                        o_res.count = wbct_pkg::sat_count(r_cnt);
                        o_res.last  = 1'b1;
                    end else begin
                        o_res = wbct_pkg::mk_result(wbct_pkg::KIND_DONE, 6'd0, 8'd0, '0,
                            1'b0, wbct_pkg::sat_count(r_cnt), 1'b1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and valid/dirty bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vp     <= '0;
            r_valid  <= '0;
            r_dirty  <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_vp     <= n_vp;
            r_valid  <= n_valid;
            r_dirty  <= n_dirty;
            r_pend_v <= n_pend_v;
        end
    end

    // Payload of the item under work.
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        r_nout <= n_nout;
        r_pend <= n_pend;
    end

endmodule
